>>> rtl/ccs_pkg.sv
// Package for the comment stripper: scan modes, error codes, byte constants
// and the command record that the front end hands to the back end.
// No dependencies.
`default_nettype none

package ccs_pkg;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_LINE  = 3'd1,
    MODE_BLOCK = 3'd2,
    MODE_STR   = 3'd3,
    MODE_STRE  = 3'd4,
    MODE_CHR   = 3'd5,
    MODE_CHRE  = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_STR  = 2'd1,
    ERR_CHR  = 2'd2
  } err_e;

  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;

  // One or two output beats caused by one input beat.
  typedef struct packed {
    logic [7:0] ch0;
    logic       hid0;
    logic [7:0] ch1;
    logic       hid1;
    logic       two;
    logic       eol;
    err_e       err;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

>>> rtl/ccs_front.sv
// Front end of the comment stripper: accepts source beats, runs the scanner
// state machine and emits one command per beat that yields output.
// Depends on ccs_pkg.
`default_nettype none

module ccs_front import ccs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] ch_i,
  input  wire logic       line_end_i,
  input  wire q_status_t  q_status_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  mode_e mode_q, mode_d;
  logic  star_q, star_d;
  logic  slash_q, slash_d;
  logic  in_acc;

  assign in_stall_o = q_status_i.full;
  assign in_acc     = in_valid_i && !q_status_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PLAIN;
      star_q  <= 1'b0;
      slash_q <= 1'b0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      star_q  <= star_d;
      slash_q <= slash_d;
    end
  end

  always_comb begin
    logic       handled;
    logic       emit;
    logic       emit_hid;
    logic [1:0] n;
    mode_d   = mode_q;
    star_d   = star_q;
    slash_d  = slash_q;
    handled  = 1'b0;
    emit     = 1'b0;
    emit_hid = 1'b0;
    n        = 2'd0;
    cmd_o    = '0;

    if (slash_q) begin
      slash_d = 1'b0;
      if (ch_i == ChSlash || ch_i == ChStar) begin
        cmd_o.ch0  = ChSlash;
        cmd_o.hid0 = 1'b1;
        cmd_o.ch1  = ch_i;
        cmd_o.hid1 = 1'b1;
        n          = 2'd2;
        mode_d     = (ch_i == ChSlash) ? MODE_LINE : MODE_BLOCK;
        star_d     = 1'b0;
        handled    = 1'b1;
      end else begin
        cmd_o.ch0  = ChSlash;
        cmd_o.hid0 = 1'b0;
        n          = 2'd1;
        mode_d     = MODE_PLAIN;
      end
    end

    if (!handled) begin
      unique case (mode_d)
        MODE_LINE: begin
          emit     = 1'b1;
          emit_hid = 1'b1;
        end
        MODE_BLOCK: begin
          emit     = 1'b1;
          emit_hid = 1'b1;
          if (star_q && ch_i == ChSlash) begin
            mode_d = MODE_PLAIN;
            star_d = 1'b0;
          end else begin
            star_d = (ch_i == ChStar);
          end
        end
        MODE_STR: begin
          emit = 1'b1;
          if (ch_i == ChBslash) begin
            mode_d = MODE_STRE;
          end else if (ch_i == ChDquote) begin
            mode_d = MODE_PLAIN;
          end
        end
        MODE_STRE: begin
          emit   = 1'b1;
          mode_d = MODE_STR;
        end
        MODE_CHR: begin
          emit = 1'b1;
          if (ch_i == ChBslash) begin
            mode_d = MODE_CHRE;
          end else if (ch_i == ChSquote) begin
            mode_d = MODE_PLAIN;
          end
        end
        MODE_CHRE: begin
          emit   = 1'b1;
          mode_d = MODE_CHR;
        end
        default: begin
          mode_d = MODE_PLAIN;
          if (ch_i == ChSlash && !line_end_i) begin
            slash_d = 1'b1;
          end else begin
            emit = 1'b1;
            if (ch_i == ChDquote) begin
              mode_d = MODE_STR;
            end else if (ch_i == ChSquote) begin
              mode_d = MODE_CHR;
            end
          end
        end
      endcase
    end

    if (emit) begin
      if (n == 2'd0) begin
        cmd_o.ch0  = ch_i;
        cmd_o.hid0 = emit_hid;
        n          = 2'd1;
      end else begin
        cmd_o.ch1  = ch_i;
        cmd_o.hid1 = emit_hid;
        n          = 2'd2;
      end
    end

    cmd_o.err = ERR_NONE;
    if (line_end_i) begin
      if (mode_d == MODE_STR || mode_d == MODE_STRE) begin
        cmd_o.err = ERR_STR;
      end else if (mode_d == MODE_CHR || mode_d == MODE_CHRE) begin
        cmd_o.err = ERR_CHR;
      end
      if (mode_d != MODE_BLOCK) begin
        mode_d = MODE_PLAIN;
      end
      star_d  = 1'b0;
      slash_d = 1'b0;
    end

    cmd_o.two = (n == 2'd2);
    cmd_o.eol = line_end_i;
    push_o    = in_acc && (n != 2'd0);
  end

endmodule

`default_nettype wire

>>> rtl/ccs_queue.sv
// Command queue between the front and back ends of the comment stripper.
// Small register file with read and write pointers. Depends on ccs_pkg.
`default_nettype none

module ccs_queue import ccs_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire cmd_t      push_cmd_i,
  input  wire logic      pop_i,
  output cmd_t           head_o,
  output q_status_t      status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(Depth));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ccs_back.sv
// Back end of the comment stripper: turns queued commands into one or two
// output beats held in an output register. Depends on ccs_pkg.
`default_nettype none

module ccs_back import ccs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       head_i,
  input  wire q_status_t  q_status_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_ch_o,
  output logic            hidden_o,
  output logic [1:0]      error_code_o,
  output logic            last_of_line_o
);

  logic       valid_q, valid_d;
  logic       phase_q, phase_d;
  logic [7:0] ch_q, ch_d;
  logic       hid_q, hid_d;
  err_e       err_q, err_d;
  logic       last_q, last_d;
  logic       take;
  logic       final_beat;

  assign take       = !valid_q || !out_stall_i;
  assign final_beat = !head_i.two || phase_q;
  assign pop_o      = take && !q_status_i.empty && final_beat;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    ch_d    = ch_q;
    hid_d   = hid_q;
    err_d   = err_q;
    last_d  = last_q;
    if (take) begin
      valid_d = !q_status_i.empty;
      if (!q_status_i.empty) begin
        if (head_i.two && !phase_q) begin
          ch_d    = head_i.ch0;
          hid_d   = head_i.hid0;
          err_d   = ERR_NONE;
          last_d  = 1'b0;
          phase_d = 1'b1;
        end else begin
          ch_d    = head_i.two ? head_i.ch1 : head_i.ch0;
          hid_d   = head_i.two ? head_i.hid1 : head_i.hid0;
          err_d   = head_i.err;
          last_d  = head_i.eol;
          phase_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    hid_q  <= hid_d;
    err_q  <= err_d;
    last_q <= last_d;
  end

  assign out_valid_o    = valid_q;
  assign out_ch_o       = ch_q;
  assign hidden_o       = hid_q;
  assign error_code_o   = err_q;
  assign last_of_line_o = last_q;

endmodule

`default_nettype wire

>>> rtl/c_comment_stripper_unit.sv
// Top level of the comment stripper: front end, command queue, back end.
// Depends on ccs_pkg, ccs_front, ccs_queue and ccs_back.
//
//   Channel  Direction  Handshake                 Beat contents
//   in       input      in_valid_i / in_stall_o   ch_i, line_end_i
//   out      output     out_valid_o / out_stall_i out_ch_o, hidden_o,
//                                                 error_code_o, last_of_line_o
//
// One input beat is accepted per cycle while the queue has room. An input
// beat yields zero, one or two output beats; the back end sends one output
// beat per cycle while out_stall_i is low, so a held slash and the beat after
// it go out as two beats. Output passes through the queue, then the output
// register. Reset clears the scanner state, queue pointers and output valid
// flag. An output stall fills the queue, after which in_stall_o rises.
`default_nettype none

module c_comment_stripper_unit import ccs_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] ch_i,
  input  wire logic       line_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_ch_o,
  output logic            hidden_o,
  output logic [1:0]      error_code_o,
  output logic            last_of_line_o
);

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;

  ccs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .line_end_i (line_end_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ccs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .status_o   (q_status)
  );

  ccs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_cmd),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_ch_o       (out_ch_o),
    .hidden_o       (hidden_o),
    .error_code_o   (error_code_o),
    .last_of_line_o (last_of_line_o)
  );

endmodule

`default_nettype wire

>>> rtl/ccs_checker.sv
// Port-level checks for the comment stripper and the bind that attaches them.
// Depends on ccs_pkg and c_comment_stripper_unit.
`default_nettype none

module ccs_checker import ccs_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] ch_i,
  input wire logic       line_end_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_ch_o,
  input wire logic       hidden_o,
  input wire logic [1:0] error_code_o,
  input wire logic       last_of_line_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(ch_i) && $stable(line_end_i))
    else $error("Input beat changed while stalled.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_ch_o) && $stable(hidden_o))
    else $error("Output beat changed while stalled.");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> last_of_line_o)
    else $error("Error code on a beat that does not end a line.");

  a_err_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> !hidden_o && error_code_o != 2'd3)
    else $error("Literal error reported on a comment beat or with a bad code.");

endmodule

bind c_comment_stripper_unit ccs_checker u_ccs_checker (.*);

`default_nettype wire
